// File: sv/ctac_pkg.sv
// ----------------------------------------------------------------------------
// ctac_pkg: shared definitions for the command line token allowlist checker
// Holds the pattern table, the character limits, the verdict codes and the
// structs that pass between the top level, the pattern cells and the output
// buffer.
// ----------------------------------------------------------------------------
package ctac_pkg;

  localparam int unsigned NUM_PATTERNS = 7;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned PAT_MAX_LEN  = 16;
  localparam int unsigned PAT_IDX_W    = 4;

  localparam logic [POS_W-1:0] POS_MAX    = 6'd63;
  localparam logic [7:0]       CHAR_LO    = 8'h20;
  localparam logic [7:0]       CHAR_HI    = 8'h7e;
  localparam logic [7:0]       CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    VERDICT_ALLOWED     = 2'd0,
    VERDICT_BAD_CHAR    = 2'd1,
    VERDICT_TOO_MANY    = 2'd2,
    VERDICT_NOT_ALLOWED = 2'd3
  } verdict_e;

  // Pattern bodies without the leading caret, padded with zero bytes.
  localparam logic [7:0] PAT_BODY [NUM_PATTERNS][PAT_MAX_LEN] = '{
    '{8'h63, 8'h6f, 8'h6e, 8'h73, 8'h6f, 8'h6c, 8'h65, 8'h3d,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h6f, 8'h6f, 8'h74, 8'h3d, 8'h73, 8'h6f, 8'h63,
      8'h69, 8'h3a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h6f, 8'h6f, 8'h74, 8'h3d, 8'h61, 8'h74, 8'h6f,
      8'h6d, 8'h69, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h71, 8'h75, 8'h69, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h76, 8'h65, 8'h72, 8'h62, 8'h6f, 8'h73, 8'h65, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h72, 8'h61, 8'h73, 8'h68, 8'h6b, 8'h65, 8'h72,
      8'h6e, 8'h65, 8'h6c, 8'h3d, 8'h32, 8'h35, 8'h36, 8'h4d}
  };

  localparam logic [POS_W-1:0] PAT_LEN [NUM_PATTERNS] = '{
    6'd8, 6'd10, 6'd11, 6'd2, 6'd5, 6'd7, 6'd16
  };

  // Bit k set: pattern k only has to match as a prefix of the token.
  localparam logic [NUM_PATTERNS-1:0] PAT_PREFIX = 7'b0000011;

  // Per-item control that every cell sees.
  typedef struct packed {
    logic clear;     // line ends: back to the reset state
    logic finish;    // current token ends after this item
    logic tok_byte;  // the item carries a byte of a token
    logic start;     // that byte opens a new token
  } ctrl_t;

  // Match results rippling along the row of cells.
  typedef struct packed {
    logic prefix;    // a prefix pattern was completed by this byte
    logic exact;     // an exact pattern equals the token so far
  } link_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [CNT_W-1:0] token_count;
  } res_t;

endpackage

// File: sv/cmdline_token_allowlist_checker.sv
// ----------------------------------------------------------------------------
// cmdline_token_allowlist_checker: command line token allowlist checker
// Scans a command line byte by byte and checks each space separated token
// against a fixed allowlist of seven patterns.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless stalled, and a line of N
// bytes takes N items, the last one flagged; the verdict item is registered
// into the output buffer as the last input item is taken. Every byte is
// compared against all seven patterns at once in a row of pattern cells,
// each holding the alive bit of its pattern, and the match findings ripple
// along the row in the same cycle. Results go through a two-entry output
// buffer; input is stalled only while both entries are full. The verdict
// is 1 on a byte outside 0x20..0x7e, 2 when a token would begin beyond
// MAX_TOKEN_COUNT tokens, 3 when some token matched no pattern, else 0;
// the first fatal error wins and the rest of the line is skipped. After
// the last item the block is ready for a new line.
module cmdline_token_allowlist_checker #(
  parameter int unsigned MAX_TOKEN_COUNT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       has_char_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o,
  output logic [7:0] token_count_o
);
  import ctac_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TOKEN_COUNT);

  logic             inside_q, inside_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             prefix_q, prefix_d;
  logic             rej_q, rej_d;
  verdict_e         fatal_q, fatal_d;
  logic [CNT_W-1:0] tokens_q, tokens_d;

  logic             acc, take, is_bad, bad_byte, space, word;
  logic             start_req, too_many;
  logic             finish_space, finish_last;
  logic [POS_W-1:0] pos_eff, pos_after, pos_cur;
  logic             prefix_after, tok_ok;
  ctrl_t            ctrl;
  link_t            links [NUM_PATTERNS+1];
  res_t             res, res_out;
  logic             buf_full;

  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    is_bad    = (char_code_i < CHAR_LO) || (char_code_i > CHAR_HI);
    take      = acc && has_char_i && (fatal_q == VERDICT_ALLOWED);
    bad_byte  = take && is_bad;
    space     = take && !is_bad && (char_code_i == CHAR_SPACE);
    word      = take && !is_bad && (char_code_i != CHAR_SPACE);
    start_req = word && !inside_q;
    too_many  = start_req && (tokens_q >= MAX_CNT);

    ctrl.tok_byte = word && !too_many;
    ctrl.start    = start_req && !too_many;

    if (bad_byte) begin
      fatal_d = VERDICT_BAD_CHAR;
    end else if (too_many) begin
      fatal_d = VERDICT_TOO_MANY;
    end else begin
      fatal_d = fatal_q;
    end
    inside_d = ctrl.tok_byte ? 1'b1 : (space ? 1'b0 : inside_q);
    tokens_d = ctrl.start ? tokens_q + 8'd1 : tokens_q;

    finish_space = space && inside_q;
    finish_last  = acc && last_i && (fatal_d == VERDICT_ALLOWED) && inside_d;
    ctrl.finish  = finish_space || finish_last;
    ctrl.clear   = acc && last_i;

    pos_eff   = ctrl.start ? '0 : pos_q;
    pos_after = (pos_eff == POS_MAX) ? pos_eff : pos_eff + 6'd1;
    pos_cur   = ctrl.tok_byte ? pos_after : pos_q;
  end

  assign links[0] = '0;

  for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_cell
    ctac_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .char_i    (char_code_i),
      .pos_eff_i (pos_eff),
      .pos_cur_i (pos_cur),
      .link_i    (links[k]),
      .link_o    (links[k+1])
    );
  end

  always_comb begin
    prefix_after = (ctrl.start ? 1'b0 : prefix_q) | links[NUM_PATTERNS].prefix;
    tok_ok       = prefix_after | links[NUM_PATTERNS].exact;
    rej_d        = rej_q | (ctrl.finish && !tok_ok);
    pos_d        = ctrl.finish ? '0 : pos_cur;
    prefix_d     = ctrl.finish ? 1'b0 : prefix_after;

    if (fatal_d != VERDICT_ALLOWED) begin
      res.verdict = fatal_d;
    end else if (rej_d) begin
      res.verdict = VERDICT_NOT_ALLOWED;
    end else begin
      res.verdict = VERDICT_ALLOWED;
    end
    res.token_count = tokens_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      pos_q    <= '0;
      prefix_q <= 1'b0;
      rej_q    <= 1'b0;
      fatal_q  <= VERDICT_ALLOWED;
      tokens_q <= '0;
    end else if (ctrl.clear) begin
      inside_q <= 1'b0;
      pos_q    <= '0;
      prefix_q <= 1'b0;
      rej_q    <= 1'b0;
      fatal_q  <= VERDICT_ALLOWED;
      tokens_q <= '0;
    end else begin
      inside_q <= inside_d;
      pos_q    <= pos_d;
      prefix_q <= prefix_d;
      rej_q    <= rej_d;
      fatal_q  <= fatal_d;
      tokens_q <= tokens_d;
    end
  end

  ctac_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ctrl.clear),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign in_stall_o    = buf_full;
  assign verdict_o     = res_out.verdict;
  assign token_count_o = res_out.token_count;

  // The token count never passes the configured limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tokens_q <= MAX_CNT)
    else $error("token count beyond limit");

  // Outside a token the position and the prefix flag stay cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inside_q |-> (pos_q == '0) && !prefix_q)
    else $error("token state left over outside a token");

  // A result item never waits in the skid entry with an empty output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> out_valid_o)
    else $error("skid entry holds an item ahead of the output register");

  // Once a fatal error is kept, the scan makes no more progress in the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fatal_q != VERDICT_ALLOWED) |-> !ctrl.tok_byte && !ctrl.finish)
    else $error("token activity after a fatal error");

endmodule

// File: sv/ctac_cell.sv
// ----------------------------------------------------------------------------
// ctac_cell: one pattern matcher in the row of cells
// Keeps the alive bit of one pattern, compares the incoming token byte with
// the pattern body and ORs its findings into the link from its neighbor.
// ----------------------------------------------------------------------------
module ctac_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctac_pkg::ctrl_t       ctrl_i,
  input  logic [7:0]            char_i,
  input  logic [ctac_pkg::POS_W-1:0] pos_eff_i,
  input  logic [ctac_pkg::POS_W-1:0] pos_cur_i,
  input  ctac_pkg::link_t       link_i,
  output ctac_pkg::link_t       link_o
);
  import ctac_pkg::*;

  localparam logic [POS_W-1:0] LEN      = PAT_LEN[IDX];
  localparam logic [POS_W-1:0] LAST_POS = PAT_LEN[IDX] - 6'd1;
  localparam logic             IS_PFX   = PAT_PREFIX[IDX];

  logic alive_q, alive_d;
  logic alive_base, hit, alive_after;

  always_comb begin
    alive_base  = ctrl_i.start ? 1'b1 : alive_q;
    hit         = ctrl_i.tok_byte && alive_base && (pos_eff_i < LEN) &&
                  (PAT_BODY[IDX][pos_eff_i[PAT_IDX_W-1:0]] == char_i);
    alive_after = ctrl_i.tok_byte ? hit : alive_q;

    link_o.prefix = link_i.prefix | (IS_PFX && hit && (pos_eff_i == LAST_POS));
    link_o.exact  = link_i.exact | (!IS_PFX && alive_after && (pos_cur_i == LEN));

    alive_d = (ctrl_i.finish || ctrl_i.clear) ? 1'b1 : alive_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b1;
    end else begin
      alive_q <= alive_d;
    end
  end

endmodule

// File: sv/ctac_skid.sv
// ----------------------------------------------------------------------------
// ctac_skid: two-entry output buffer
// Holds the result item in an output register and one more in a skid entry,
// so the input side sees a registered stall only.
// ----------------------------------------------------------------------------
module ctac_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctac_pkg::res_t res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ctac_pkg::res_t res_o
);
  import ctac_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  always_comb begin
    pop          = out_valid_q && !out_stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
